// File: rtl/lapl_pkg.sv
// ----------------------------------------------------------------------------
// lapl_pkg
// Shared constants, register codes and control types of the Laplacian stencil.
// ----------------------------------------------------------------------------
package lapl_pkg;

  localparam int LAPL_MAX_COLS    = 1024;
  localparam int LAPL_SAMPLE_BITS = 16;
  localparam int LAPL_FRAC_BITS   = 16;

  localparam int OUT_BITS    = 36;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int ROWS_W     = 16;
  localparam int COLS_CFG_W = 11;
  localparam int SCALE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS = 2'd0,
    REG_NUM_COLS = 2'd1,
    REG_SCALE_X  = 2'd2,
    REG_SCALE_Y  = 2'd3
  } cfg_reg_t;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  localparam logic [ROWS_W-1:0]     NUM_ROWS_RST = 16'd1;
  localparam logic [COLS_CFG_W-1:0] NUM_COLS_RST = 11'd1;
  localparam logic [SCALE_W-1:0]    SCALE_RST    = 32'd65536;

  typedef struct packed {
    logic has_up;
    logic has_left;
    logic has_right;
    logic last;
  } op_flags_t;

endpackage

// File: rtl/lapl_linemem.sv
// ----------------------------------------------------------------------------
// lapl_linemem
// Line store: one write port, two registered read ports with write-through.
// ----------------------------------------------------------------------------
module lapl_linemem import lapl_pkg::*; #(
  parameter int DEPTH = LAPL_MAX_COLS,
  parameter int WIDTH = LAPL_SAMPLE_BITS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
    rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
  end

endmodule

// File: rtl/lapl_ctrl.sv
// ----------------------------------------------------------------------------
// lapl_ctrl
// Raster counters, line store addressing and boundary flags for each item.
// ----------------------------------------------------------------------------
module lapl_ctrl import lapl_pkg::*; #(
  parameter int MAX_COLS    = LAPL_MAX_COLS,
  parameter int SAMPLE_BITS = LAPL_SAMPLE_BITS,
  localparam int AW = $clog2(MAX_COLS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          mode,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [ROWS_W-1:0]             num_rows,
  input  logic [COLS_CFG_W-1:0]         num_cols,
  output logic [AW-1:0]                 raddr_here,
  output logic [AW-1:0]                 raddr_left,
  output logic [AW-1:0]                 raddr_right,
  output logic                          we,
  output logic [AW-1:0]                 waddr,
  output logic signed [SAMPLE_BITS-1:0] new_value,
  output logic                          op_valid,
  output op_flags_t                     op_flags
);

  localparam int CW = $clog2(MAX_COLS + 1);

  logic [ROWS_W-1:0] row_idx, row_idx_next, rows;
  logic [AW-1:0]     col_idx, col_idx_next;
  logic [AW-1:0]     emit_cnt, emit_cnt_next;
  logic [CW-1:0]     cols;
  logic              draining, draining_next, at_end;
  logic              sample_ok, drain_ok;
  logic [AW-1:0]     c_cur, c_next;

  function automatic logic [AW-1:0] clamp_col(input logic [AW-1:0] cnt,
                                              input logic [CW-1:0] cols_in);
    logic [AW-1:0] last_col;
    last_col = AW'(cols_in - CW'(1));
    return (CW'(cnt) >= cols_in) ? last_col : cnt;
  endfunction

  always_comb begin
    rows = (num_rows == '0) ? ROWS_W'(1) : num_rows;
    if (num_cols == '0) begin
      cols = CW'(1);
    end else if (32'(num_cols) > 32'(MAX_COLS)) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(num_cols);
    end

    draining  = row_idx >= rows;
    c_cur     = clamp_col(draining ? emit_cnt : col_idx, cols);
    at_end    = (CW'(c_cur) + CW'(1)) >= cols;
    sample_ok = !draining && mode == MODE_SAMPLE;
    drain_ok  = draining && mode == MODE_DRAIN;

    we        = fire && (sample_ok || drain_ok);
    waddr     = c_cur;
    new_value = draining ? '0 : sample;
    op_valid  = fire && (drain_ok || (sample_ok && row_idx != '0));

    op_flags.has_up    = draining ? (rows >= ROWS_W'(2)) : (row_idx >= ROWS_W'(2));
    op_flags.has_left  = c_cur != '0;
    op_flags.has_right = !at_end;
    op_flags.last      = draining && at_end;

    row_idx_next  = row_idx;
    col_idx_next  = col_idx;
    emit_cnt_next = emit_cnt;
    if (we) begin
      if (draining) begin
        if (at_end) begin
          row_idx_next  = '0;
          col_idx_next  = '0;
          emit_cnt_next = '0;
        end else begin
          emit_cnt_next = c_cur + AW'(1);
        end
      end else begin
        if (at_end) begin
          col_idx_next = '0;
          row_idx_next = row_idx + ROWS_W'(1);
        end else begin
          col_idx_next = c_cur + AW'(1);
        end
      end
    end

    // prefetch the window of the following item
    draining_next = row_idx_next >= rows;
    c_next        = clamp_col(draining_next ? emit_cnt_next : col_idx_next, cols);
    raddr_here    = c_next;
    raddr_left    = c_next - AW'(1);
    raddr_right   = c_next + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_idx  <= '0;
      col_idx  <= '0;
      emit_cnt <= '0;
    end else begin
      row_idx  <= row_idx_next;
      col_idx  <= col_idx_next;
      emit_cnt <= emit_cnt_next;
    end
  end

endmodule

// File: rtl/lapl_arith.sv
// ----------------------------------------------------------------------------
// lapl_arith
// Elastic four-stage datapath: differences, weighting, clipping, sum, shift and saturation.
// ----------------------------------------------------------------------------
module lapl_arith import lapl_pkg::*; #(
  parameter int SAMPLE_BITS = LAPL_SAMPLE_BITS,
  parameter int FRAC_BITS   = LAPL_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  op_flags_t                     flags,
  input  logic signed [SAMPLE_BITS-1:0] up,
  input  logic signed [SAMPLE_BITS-1:0] mid,
  input  logic signed [SAMPLE_BITS-1:0] below,
  input  logic signed [SAMPLE_BITS-1:0] left,
  input  logic signed [SAMPLE_BITS-1:0] right,
  input  logic [SCALE_W-1:0]            scale_x,
  input  logic [SCALE_W-1:0]            scale_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [OUT_BITS-1:0]           laplacian,
  output logic                          frame_last
);

  localparam int DW    = SAMPLE_BITS + 2;
  localparam int MW    = SAMPLE_BITS + 1;
  localparam int PW    = MW + SCALE_W;
  localparam int CMPW  = (PW > 63) ? PW : 63;
  localparam int TW    = 63;
  localparam int SUM_W = TW + 2;

  localparam logic [CMPW-1:0] TERM_LIM = CMPW'(64'h4000_0000_0000_0000);
  localparam logic signed [SUM_W-1:0] OUT_MAX = (SUM_W'(1) << (OUT_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;

  logic en1, en2, en3, en4;

  logic signed [DW-1:0] up_x, mid_x2, below_x, left_x, right_x, dx, dy;
  logic [MW-1:0]        mag_x, mag_y;

  logic                 s1_valid, s1_neg_x, s1_neg_y, s1_last;
  logic [MW-1:0]        s1_mag_x, s1_mag_y;
  logic                 s2_valid, s2_neg_x, s2_neg_y, s2_last;
  logic [PW-1:0]        s2_prod_x, s2_prod_y;
  logic [TW-1:0]        clip_x, clip_y;
  logic signed [TW:0]   term_x, term_y;
  logic                 s3_valid, s3_last;
  logic signed [TW:0]   s3_term_x, s3_term_y;
  logic signed [SUM_W-1:0] sum, quot;
  logic [OUT_BITS-1:0]  lap_sat;

  assign en4      = !out_valid || out_ready;
  assign en3      = !s3_valid || en4;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  always_comb begin
    up_x    = flags.has_up ? {{2{up[SAMPLE_BITS-1]}}, up} : '0;
    left_x  = flags.has_left ? {{2{left[SAMPLE_BITS-1]}}, left} : '0;
    right_x = flags.has_right ? {{2{right[SAMPLE_BITS-1]}}, right} : '0;
    below_x = {{2{below[SAMPLE_BITS-1]}}, below};
    mid_x2  = {mid[SAMPLE_BITS-1], mid, 1'b0};
    dx      = up_x - mid_x2 + below_x;
    dy      = left_x - mid_x2 + right_x;
    mag_x   = dx[DW-1] ? MW'(-dx) : MW'(dx);
    mag_y   = dy[DW-1] ? MW'(-dy) : MW'(dy);
  end

  always_comb begin
    clip_x = (CMPW'(s2_prod_x) > TERM_LIM) ? TW'(TERM_LIM) : TW'(s2_prod_x);
    clip_y = (CMPW'(s2_prod_y) > TERM_LIM) ? TW'(TERM_LIM) : TW'(s2_prod_y);
    term_x = s2_neg_x ? -$signed({1'b0, clip_x}) : $signed({1'b0, clip_x});
    term_y = s2_neg_y ? -$signed({1'b0, clip_y}) : $signed({1'b0, clip_y});
  end

  always_comb begin
    sum  = $signed({s3_term_x[TW], s3_term_x}) + $signed({s3_term_y[TW], s3_term_y});
    quot = sum >>> FRAC_BITS;
    if (quot > OUT_MAX) begin
      lap_sat = OUT_BITS'(OUT_MAX);
    end else if (quot < OUT_MIN) begin
      lap_sat = OUT_BITS'(OUT_MIN);
    end else begin
      lap_sat = OUT_BITS'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) s1_valid  <= in_valid;
      if (en2) s2_valid  <= s1_valid;
      if (en3) s3_valid  <= s2_valid;
      if (en4) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mag_x <= mag_x;
      s1_mag_y <= mag_y;
      s1_neg_x <= dx[DW-1];
      s1_neg_y <= dy[DW-1];
      s1_last  <= flags.last;
    end
    if (en2) begin
      s2_prod_x <= PW'(s1_mag_x) * PW'(scale_x);
      s2_prod_y <= PW'(s1_mag_y) * PW'(scale_y);
      s2_neg_x  <= s1_neg_x;
      s2_neg_y  <= s1_neg_y;
      s2_last   <= s1_last;
    end
    if (en3) begin
      s3_term_x <= term_x;
      s3_term_y <= term_y;
      s3_last   <= s2_last;
    end
    if (en4) begin
      laplacian  <= lap_sat;
      frame_last <= s3_last;
    end
  end

endmodule

// File: rtl/laplacian_stencil_2d_top.sv
// ----------------------------------------------------------------------------
// laplacian_stencil_2d_top
// Five-point Laplacian over a raster grid with zero boundary, one row latency.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata: sample   tuser: mode
//   m_*      out  m_tvalid/m_tready  tdata: laplacian  tlast: frame_last
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while s_tready is held high; a taken item's result passes
// through each datapath stage in order (s1, s2, s3) into the output register.
// Line store reads for the next item are issued at the edge that takes the
// current one, so items follow back to back.
// s_tready drops for one cycle after reset and after each register write.
// A stalled output register holds the pipeline; s_tready drops once every stage is full.
// ----------------------------------------------------------------------------
module laplacian_stencil_2d_top import lapl_pkg::*; #(
  parameter int MAX_COLS    = LAPL_MAX_COLS,
  parameter int SAMPLE_BITS = LAPL_SAMPLE_BITS,
  parameter int FRAC_BITS   = LAPL_FRAC_BITS,
  localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample
  input  logic [0:0]             s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // laplacian
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_COLS);

  logic [ROWS_W-1:0]     num_rows;
  logic [COLS_CFG_W-1:0] num_cols;
  logic [SCALE_W-1:0]    scale_x, scale_y;
  logic                  cfg_hold;
  logic                  cfg_fire, fire, dp_ready;

  logic signed [SAMPLE_BITS-1:0] sample, new_value;
  logic signed [SAMPLE_BITS-1:0] above_here, above_left, center_here, center_right;
  logic [AW-1:0]         raddr_here, raddr_left, raddr_right, waddr;
  logic                  we, op_valid;
  op_flags_t             op_flags;
  logic [OUT_BITS-1:0]   laplacian;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s_tready  = dp_ready && !cfg_hold;
  assign fire      = s_tvalid && s_tready;
  assign sample    = s_tdata[SAMPLE_BITS-1:0];
  assign m_tdata   = OUT_TDATA_W'(laplacian);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= NUM_ROWS_RST;
      num_cols <= NUM_COLS_RST;
      scale_x  <= SCALE_RST;
      scale_y  <= SCALE_RST;
      cfg_hold <= 1'b1;
    end else begin
      cfg_hold <= cfg_fire;
      if (cfg_fire) begin
        case (cfg_reg_t'(cfg_index))
          REG_NUM_ROWS: num_rows <= cfg_data[ROWS_W-1:0];
          REG_NUM_COLS: num_cols <= cfg_data[COLS_CFG_W-1:0];
          REG_SCALE_X:  scale_x  <= cfg_data[SCALE_W-1:0];
          REG_SCALE_Y:  scale_y  <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  lapl_ctrl #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .mode        (s_tuser[0]),
    .sample      (sample),
    .num_rows    (num_rows),
    .num_cols    (num_cols),
    .raddr_here  (raddr_here),
    .raddr_left  (raddr_left),
    .raddr_right (raddr_right),
    .we          (we),
    .waddr       (waddr),
    .new_value   (new_value),
    .op_valid    (op_valid),
    .op_flags    (op_flags)
  );

  lapl_linemem #(
    .DEPTH (MAX_COLS),
    .WIDTH (SAMPLE_BITS)
  ) u_above (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (center_here),
    .raddr_a (raddr_here),
    .raddr_b (raddr_left),
    .rdata_a (above_here),
    .rdata_b (above_left)
  );

  lapl_linemem #(
    .DEPTH (MAX_COLS),
    .WIDTH (SAMPLE_BITS)
  ) u_center (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (new_value),
    .raddr_a (raddr_here),
    .raddr_b (raddr_right),
    .rdata_a (center_here),
    .rdata_b (center_right)
  );

  lapl_arith #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_arith (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (op_valid),
    .in_ready   (dp_ready),
    .flags      (op_flags),
    .up         (above_here),
    .mid        (center_here),
    .below      (new_value),
    .left       (above_left),
    .right      (center_right),
    .scale_x    (scale_x),
    .scale_y    (scale_y),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .laplacian  (laplacian),
    .frame_last (m_tlast)
  );

endmodule

// File: rtl/lapl_checker.sv
// ----------------------------------------------------------------------------
// lapl_checker
// Port-level checks of the Laplacian stencil, bound to the top level.
// ----------------------------------------------------------------------------
module lapl_checker import lapl_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tlast,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output item changed");

  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready)
    else $error("input taken straight after a register write");

  a_reset_block: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_tready)
    else $error("input ready in the first cycle after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_BITS] == '0)
    else $error("output padding bits not zero");

endmodule

bind laplacian_stencil_2d_top lapl_checker u_lapl_checker (.*);

// File: tb/sv/tb_laplacian_stencil_2d_top.sv
// ----------------------------------------------------------------------------
// tb_laplacian_stencil_2d_top
// Self-checking bench for the five-point Laplacian stencil. Raster frames of
// random size and content, with stray drain ticks and stray samples, are
// streamed into the block under random idling on both sides. A scoreboard
// tracks the line stores and counters, predicts each result and checks every
// result item in order. It also runs register changes mid-frame and a long
// output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_laplacian_stencil_2d_top;
  import lapl_pkg::*;

  localparam int IN_W = ((LAPL_SAMPLE_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam longint unsigned TERM_LIM = 64'd1 << 62;
  localparam longint OUT_MAX = (64'sd1 <<< (OUT_BITS - 1)) - 1;
  localparam longint OUT_MIN = -(64'sd1 <<< (OUT_BITS - 1));

  typedef struct {
    logic [OUT_BITS-1:0] value;
    logic                last;
  } point_t;

  class laplacian_board;
    longint       above_row [LAPL_MAX_COLS];
    longint       centre_row[LAPL_MAX_COLS];
    int unsigned  row_idx, col_idx, drain_col;
    int unsigned  rows_reg, cols_reg;
    bit [31:0]    scale_x, scale_y;
    point_t       pending_points[$];
    int           errors;
    int           checked;

    function new();
      foreach (above_row[i]) begin
        above_row[i] = 0;
        centre_row[i] = 0;
      end
      row_idx = 0;
      col_idx = 0;
      drain_col = 0;
      rows_reg = NUM_ROWS_RST;
      cols_reg = NUM_COLS_RST;
      scale_x = SCALE_RST;
      scale_y = SCALE_RST;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        REG_NUM_ROWS: rows_reg = d[ROWS_W-1:0];
        REG_NUM_COLS: cols_reg = d[COLS_CFG_W-1:0];
        REG_SCALE_X:  scale_x = d;
        REG_SCALE_Y:  scale_y = d;
        default: ;
      endcase
    endfunction

    function longint weigh(longint d, bit [31:0] k);
      longint unsigned mag;
      longint unsigned p;
      mag = (d < 0) ? -d : d;
      if (k != 0 && mag > TERM_LIM / k) p = TERM_LIM;
      else p = mag * k;
      if (p > TERM_LIM) p = TERM_LIM;
      return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    function longint point_laplacian(int unsigned c, bit has_up, longint below,
                                     int unsigned cols);
      longint mid, up, left, right, sum, q;
      mid = centre_row[c];
      up = has_up ? above_row[c] : 0;
      left = (c > 0) ? above_row[c-1] : 0;
      right = (c + 1 < cols) ? centre_row[c+1] : 0;
      sum = weigh(up - 2 * mid + below, scale_x) + weigh(left - 2 * mid + right, scale_y);
      q = sum >>> LAPL_FRAC_BITS;
      if (q > OUT_MAX) q = OUT_MAX;
      if (q < OUT_MIN) q = OUT_MIN;
      return q;
    endfunction

    // returns 0 when the block drops the item
    function bit note_item(logic mode, logic [IN_W-1:0] smp);
      int unsigned rows, cols, c;
      longint s, q;
      rows = (rows_reg != 0) ? rows_reg : 1;
      cols = (cols_reg != 0) ? cols_reg : 1;
      if (cols > LAPL_MAX_COLS) cols = LAPL_MAX_COLS;
      if (row_idx >= rows) begin
        if (mode == MODE_SAMPLE) return 0;
        c = (drain_col < cols) ? drain_col : cols - 1;
        q = point_laplacian(c, rows >= 2, 0, cols);
        above_row[c] = centre_row[c];
        centre_row[c] = 0;
        if (c + 1 >= cols) begin
          pending_points.push_back('{q[OUT_BITS-1:0], 1'b1});
          row_idx = 0;
          col_idx = 0;
          drain_col = 0;
        end else begin
          pending_points.push_back('{q[OUT_BITS-1:0], 1'b0});
          drain_col = c + 1;
        end
        return 1;
      end
      if (mode == MODE_DRAIN) return 0;
      c = (col_idx < cols) ? col_idx : cols - 1;
      s = $signed(smp[LAPL_SAMPLE_BITS-1:0]);
      if (row_idx >= 1) begin
        q = point_laplacian(c, row_idx >= 2, s, cols);
        pending_points.push_back('{q[OUT_BITS-1:0], 1'b0});
      end
      above_row[c] = centre_row[c];
      centre_row[c] = s;
      if (c + 1 >= cols) begin
        col_idx = 0;
        row_idx = row_idx + 1;
      end else begin
        col_idx = c + 1;
      end
      return 1;
    endfunction

    function void check_point(logic [OUT_BITS-1:0] value, logic last);
      point_t want;
      if (pending_points.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: laplacian %0d last %0b", $signed(value), last);
        return;
      end
      want = pending_points.pop_front();
      checked++;
      if (value !== want.value || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at result %0d: laplacian %0d last %0b, expected %0d last %0b",
                   checked, $signed(value), last, $signed(want.value), want.last);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata = '0;
  logic [0:0]             s_tuser = MODE_SAMPLE;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_reg_t               cfg_index = REG_NUM_ROWS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  laplacian_board board;
  int cycle_count = 0;
  int tx_style = 1;
  int rx_style = 1;
  bit rx_hold_req = 1'b0;
  int used_items = 0;
  int dropped_items = 0;
  int frames_done = 0;

  laplacian_stencil_2d_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_laplacian_stencil_2d_top NOT OK");
      $finish;
    end
  end

  function automatic int draw_gap(int style);
    case (style)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return SCALE_RST;
      3: return $urandom_range(0, 262144);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic mode, logic [IN_W-1:0] smp);
    int gap;
    gap = draw_gap(tx_style);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= smp;
    do @(posedge clk); while (!s_tready);
    if (board.note_item(mode, smp)) used_items++;
    else dropped_items++;
  endtask

  // drop valid and wait until every result is out and the pipeline is empty
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frame(int unsigned rows, int unsigned cols, bit noisy);
    for (int unsigned k = 0; k < rows * cols; k++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_item(MODE_DRAIN, pick_sample());
      send_item(MODE_SAMPLE, pick_sample());
    end
    for (int unsigned k = 0; k < cols; k++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_item(MODE_SAMPLE, pick_sample());
      send_item(MODE_DRAIN, pick_sample());
    end
    frames_done++;
  endtask

  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (rx_hold_req) begin
        stall = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        stall = draw_gap(rx_style);
      end
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_point(m_tdata[OUT_BITS-1:0], m_tlast);
    end
  end

  initial begin
    int unsigned rows, cols;
    int start_items;
    board = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: one by one grid, stray drain and stray sample
    send_item(MODE_DRAIN, 16'h0000);
    send_item(MODE_SAMPLE, 16'h7FFF);
    send_item(MODE_SAMPLE, 16'h8000);
    send_item(MODE_DRAIN, 16'hFFFF);
    settle();

    write_reg(REG_NUM_ROWS, 32'd3);
    write_reg(REG_NUM_COLS, 32'd3);
    write_reg(REG_SCALE_X, 32'hFFFF_FFFF);
    write_reg(REG_SCALE_Y, 32'd0);
    for (int k = 0; k < 9; k++) send_item(MODE_SAMPLE, (k % 2) ? 16'h8000 : 16'h7FFF);
    for (int k = 0; k < 3; k++) send_item(MODE_DRAIN, 16'h0000);
    settle();

    // shrink columns and rows part way through a frame
    write_reg(REG_NUM_ROWS, 32'd65535);
    write_reg(REG_NUM_COLS, 32'd4);
    write_reg(REG_SCALE_X, SCALE_RST);
    write_reg(REG_SCALE_Y, 32'hFFFF_FFFF);
    for (int k = 0; k < 6; k++) send_item(MODE_SAMPLE, pick_sample());
    settle();
    write_reg(REG_NUM_COLS, 32'd2);
    send_item(MODE_SAMPLE, 16'h8000);
    settle();
    write_reg(REG_NUM_ROWS, 32'd2);
    for (int k = 0; k < 2; k++) send_item(MODE_DRAIN, 16'h0000);
    settle();

    write_reg(REG_NUM_ROWS, 32'd0);
    write_reg(REG_NUM_COLS, 32'd0);
    send_item(MODE_SAMPLE, 16'h7FFF);
    send_item(MODE_DRAIN, 16'h0000);
    settle();

    // long output stall while input runs flat out
    tx_style = 0;
    rx_style = 0;
    write_reg(REG_NUM_ROWS, 32'd3);
    write_reg(REG_NUM_COLS, 32'd8);
    rx_hold_req = 1'b1;
    run_frame(3, 8, 1'b0);

    start_items = used_items + dropped_items;
    while (used_items + dropped_items - start_items < 390) begin
      rows = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
      cols = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 64) : $urandom_range(1, 10);
      if (cols > 10 && rows > 3) rows = $urandom_range(1, 3);
      settle();
      tx_style = $urandom_range(0, 2);
      rx_style = $urandom_range(0, 2);
      write_reg(REG_NUM_ROWS, (rows == 1 && $urandom_range(0, 1)) ? 32'd0 : rows);
      write_reg(REG_NUM_COLS, (cols == 1 && $urandom_range(0, 1)) ? 32'd0 : cols);
      if ($urandom_range(0, 1)) begin
        write_reg(REG_SCALE_X, pick_scale());
        write_reg(REG_SCALE_Y, pick_scale());
      end
      run_frame(rows, cols, $urandom_range(0, 3) != 0);
    end

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d frames, %0d items taken, %0d items dropped by the block",
             frames_done, used_items, dropped_items);
    $display("checked %0d results, %0d failures", board.checked, board.errors);
    if (board.errors == 0 && board.pending_points.size() == 0) begin
      $display("tb_laplacian_stencil_2d_top OK");
    end else begin
      $display("tb_laplacian_stencil_2d_top NOT OK");
    end
    $finish;
  end

endmodule
